>>> sv/float_format_converter_macros.svh
// Assertion macros shared by the converter.
`ifndef FLOAT_FORMAT_CONVERTER_MACROS_SVH
`define FLOAT_FORMAT_CONVERTER_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define FFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked at every edge, including during reset.
`define FFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> sv/ffc_pkg.sv
package ffc_pkg;

  // Format codes.
  localparam logic [1:0] FMT_HALF   = 2'd0;
  localparam logic [1:0] FMT_SINGLE = 2'd1;
  localparam logic [1:0] FMT_DOUBLE = 2'd2;

  localparam int unsigned PipeDepth = 4;

  // Unpacked source, handed from the normalise stage onwards.
  typedef struct packed {
    logic [1:0]  dfmt;
    logic        sign;
    logic        special;   // result fully known already
    logic [63:0] spec_bits; // that result, unmasked
    logic [63:0] sig;       // normalised significand, top bit set
    logic signed [13:0] eb; // biased destination exponent
  } ffc_dec_t;

  // Rounding stage output, also used for the decode stage register.
  typedef struct packed {
    logic [1:0]  dfmt;
    logic        sign;
    logic        special;
    logic [63:0] spec_bits;
    logic        ovf;
    logic [63:0] rsig;
  } ffc_rnd_t;

  function automatic logic [1:0] fix_fmt(input logic [1:0] f);
    fix_fmt = (f == 2'd3) ? FMT_DOUBLE : f;
  endfunction

  function automatic logic [5:0] mbits(input logic [1:0] f);
    case (f)
      FMT_HALF:   mbits = 6'd10;
      FMT_SINGLE: mbits = 6'd23;
      default:    mbits = 6'd52;
    endcase
  endfunction

  function automatic logic [10:0] bias(input logic [1:0] f);
    case (f)
      FMT_HALF:   bias = 11'd15;
      FMT_SINGLE: bias = 11'd127;
      default:    bias = 11'd1023;
    endcase
  endfunction

  function automatic logic [10:0] emax(input logic [1:0] f);
    case (f)
      FMT_HALF:   emax = 11'h1f;
      FMT_SINGLE: emax = 11'hff;
      default:    emax = 11'h7ff;
    endcase
  endfunction

  function automatic logic [63:0] wmask(input logic [1:0] f);
    case (f)
      FMT_HALF:   wmask = 64'h0000_0000_0000_ffff;
      FMT_SINGLE: wmask = 64'h0000_0000_ffff_ffff;
      default:    wmask = '1;
    endcase
  endfunction

  function automatic logic [63:0] sign_pos(input logic [1:0] f);
    case (f)
      FMT_HALF:   sign_pos = 64'h0000_0000_0000_8000;
      FMT_SINGLE: sign_pos = 64'h0000_0000_8000_0000;
      default:    sign_pos = 64'h8000_0000_0000_0000;
    endcase
  endfunction

endpackage

>>> sv/ffc_pipe_ctrl.sv
// Elastic pipeline control: one valid bit per stage, a stage advances when
// the stage after it is empty or moving.
module ffc_pipe_ctrl #(
  parameter int unsigned Depth = ffc_pkg::PipeDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_ready,
  output logic [Depth-1:0] adv,
  output logic             out_valid
);
  logic [Depth-1:0] vld_r;
  logic [Depth-1:0] vld_nxt;

  // Advance enables from the output end backwards.
  always_comb begin
    adv[Depth-1] = !vld_r[Depth-1] || out_ready;
    for (int i = Depth - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i-1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[Depth-1];
endmodule

>>> sv/float_format_converter.sv
// Flow: a word accepted into s1_r moves on through s2_r and s3_r to res_r.
// Throughput: one word per cycle unless stalled, through four stages (decode,
// normalise, round, pack); a stalled output holds only the full stages behind it.
// Reset: synchronous active-low rst_n clears the stage valid bits; the
// datapath registers are not reset.
module float_format_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_source_bits,
  input  logic [1:0]  in_source_format,
  input  logic [1:0]  in_dest_format,
  input  logic        in_saturate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_bits
);
`include "float_format_converter_macros.svh"

  localparam int unsigned Depth = ffc_pkg::PipeDepth;

  logic [Depth-1:0] adv;

  ffc_pipe_ctrl #(.Depth(Depth)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .out_ready(out_ready),
    .adv(adv), .out_valid(out_valid)
  );
  assign in_ready = adv[0];

  // Stage 1: unpack, classify, build special results.
  ffc_pkg::ffc_rnd_t s1_r, s1_nxt; // rsig holds raw significand, ovf unused
  logic signed [13:0] s1_ex_r, s1_ex_nxt; // exponent of significand lsb

  always_comb begin
    logic [1:0]  sf, df;
    logic [63:0] bits, m, p;
    logic [10:0] e, smax;
    logic [5:0]  sm, dm;
    logic        sgn, nan;
    sf = ffc_pkg::fix_fmt(in_source_format);
    df = ffc_pkg::fix_fmt(in_dest_format);
    sm = ffc_pkg::mbits(sf);
    dm = ffc_pkg::mbits(df);
    smax = ffc_pkg::emax(sf);
    bits = in_source_bits & ffc_pkg::wmask(sf);
    sgn = |(bits & ffc_pkg::sign_pos(sf));
    e = 11'((bits >> sm) & 64'(smax));
    m = bits & ((64'd1 << sm) - 64'd1);
    nan = (e == smax) && (m != 64'd0);
    if (dm >= sm) p = m << (dm - sm);
    else p = m >> (sm - dm);
    p = p | (64'd1 << (dm - 6'd1));
    s1_nxt.dfmt = df;
    s1_nxt.sign = sgn;
    s1_nxt.ovf = 1'b0;
    s1_nxt.special = 1'b1;
    s1_nxt.spec_bits = (sgn ? ffc_pkg::sign_pos(df) : 64'd0)
                       | (64'(ffc_pkg::emax(df)) << dm);
    s1_nxt.rsig = m;
    s1_ex_nxt = 14'sd1 - 14'(signed'({3'b0, ffc_pkg::bias(sf)}))
                - 14'(signed'({8'b0, sm}));
    if (nan && in_saturate) begin
      s1_nxt.spec_bits = 64'd0;
    end else if (sf == df) begin
      s1_nxt.spec_bits = bits;
    end else if (e == smax) begin
      if (nan) s1_nxt.spec_bits = s1_nxt.spec_bits | p;
    end else if (e == 11'd0 && m == 64'd0) begin
      s1_nxt.spec_bits = sgn ? ffc_pkg::sign_pos(df) : 64'd0;
    end else begin
      s1_nxt.special = 1'b0;
      if (e != 11'd0) begin
        s1_nxt.rsig = m | (64'd1 << sm);
        s1_ex_nxt = 14'(signed'({3'b0, e})) - 14'(signed'({3'b0, ffc_pkg::bias(sf)}))
                    - 14'(signed'({8'b0, sm}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_r <= s1_nxt;
      s1_ex_r <= s1_ex_nxt;
    end
  end

  // Stage 2: normalise the significand and form the destination exponent.
  ffc_pkg::ffc_dec_t s2_r, s2_nxt;

  always_comb begin
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (s1_r.rsig[i]) lz = 6'(63 - i);
    end
    s2_nxt.dfmt = s1_r.dfmt;
    s2_nxt.sign = s1_r.sign;
    s2_nxt.special = s1_r.special;
    s2_nxt.spec_bits = s1_r.spec_bits;
    s2_nxt.sig = s1_r.rsig << lz;
    s2_nxt.eb = s1_ex_r - 14'(signed'({8'b0, lz})) + 14'sd63
                + 14'(signed'({3'b0, ffc_pkg::bias(s1_r.dfmt)}));
  end

  always_ff @(posedge clk) begin
    if (adv[1]) s2_r <= s2_nxt;
  end

  // Stage 3: shift right with round to nearest, ties to even.
  ffc_pkg::ffc_rnd_t s3_r, s3_nxt;

  always_comb begin
    logic [7:0]  sh;
    logic [63:0] q, rem, half;
    logic [5:0]  dm;
    logic        up;
    dm = ffc_pkg::mbits(s2_r.dfmt);
    sh = 8'd63 - {2'b0, dm};
    if (s2_r.eb < 14'sd1) begin
      if ((14'sd1 - s2_r.eb) > 14'sd70) sh = sh + 8'd70;
      else sh = sh + 8'(14'sd1 - s2_r.eb);
    end
    if (sh >= 8'd64) begin
      q = 64'd0;
      rem = (sh == 8'd64) ? s2_r.sig : 64'd0;
      half = (sh == 8'd64) ? 64'h8000_0000_0000_0000 : 64'd0;
      up = (sh == 8'd64) && (rem > half);
    end else begin
      q = s2_r.sig >> sh;
      rem = s2_r.sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 8'd1);
      up = (rem > half) || (rem == half && q[0]);
    end
    s3_nxt.dfmt = s2_r.dfmt;
    s3_nxt.sign = s2_r.sign;
    s3_nxt.special = s2_r.special;
    s3_nxt.spec_bits = s2_r.spec_bits;
    s3_nxt.ovf = s2_r.eb >= 14'(signed'({3'b0, ffc_pkg::emax(s2_r.dfmt)}));
    s3_nxt.rsig = q + 64'(up);
    if (s2_r.eb >= 14'sd1) begin
      s3_nxt.rsig = s3_nxt.rsig + (64'(s2_r.eb - 14'sd1) << dm);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) s3_r <= s3_nxt;
  end

  // Stage 4: overflow check and packing.
  logic [63:0] res_r, res_nxt;

  always_comb begin
    logic [63:0] sgnb, infb;
    sgnb = s3_r.sign ? ffc_pkg::sign_pos(s3_r.dfmt) : 64'd0;
    infb = sgnb | (64'(ffc_pkg::emax(s3_r.dfmt)) << ffc_pkg::mbits(s3_r.dfmt));
    if (s3_r.special) res_nxt = s3_r.spec_bits;
    else if (s3_r.ovf || s3_r.rsig >= (infb & ~sgnb)) res_nxt = infb;
    else res_nxt = sgnb | s3_r.rsig;
    res_nxt = res_nxt & ffc_pkg::wmask(s3_r.dfmt);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) res_r <= res_nxt;
  end

  assign out_result_bits = res_r;

  // Checks.
  `FFC_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_result_bits), "result word changed while stalled")
  `FFC_ASSERT(a_ready_free, !out_valid |-> in_ready, "input blocked with empty output stage")
  `FFC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "valid after reset")
endmodule
